>>> hdl/olapd_pkg.sv
// shared types and constants for the ordered list core
package olapd_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned VALUE_WIDTH   = 32;
   localparam int unsigned COUNT_WIDTH   = 5;

   typedef enum logic [1:0] {
      REQ_APPEND = 2'd0,
      REQ_POP    = 2'd1,
      REQ_DELETE = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_POP_DATA,
      S_SCAN,
      S_SHIFT,
      S_RESP
   } state_type;

endpackage

>>> hdl/olapd_alu.sv
// shared unit: modular address adder and value compare
module olapd_alu #(
   parameter int unsigned DEPTH = olapd_pkg::DEPTH_DEFAULT,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic [AW-1:0]                        addr_a,
   input  logic [AW-1:0]                        addr_b,
   input  logic signed [olapd_pkg::VALUE_WIDTH-1:0] cmp_a,
   input  logic signed [olapd_pkg::VALUE_WIDTH-1:0] cmp_b,
   output logic [AW-1:0]                        addr_sum,
   output logic                                 cmp_equal
);
   import olapd_pkg::*;

   logic [AW:0] raw_sum;
   logic [AW:0] wrapped;

   assign raw_sum = {1'b0, addr_a} + {1'b0, addr_b};

   always_comb begin
      if (raw_sum >= (AW+1)'(DEPTH)) begin
         wrapped = raw_sum - (AW+1)'(DEPTH);
      end else begin
         wrapped = raw_sum;
      end
   end

   assign addr_sum  = wrapped[AW-1:0];
   assign cmp_equal = (cmp_a == cmp_b);

endmodule

>>> hdl/ordered_list_append_pop_delete_core.sv
// ordered list core: append at tail, pop head, delete first match, in a circular memory
//
// The list lives in a single-port-read, single-port-write memory used as a circular
// buffer, so append and pop touch one entry: append answers from the dispatch state, pop
// from the pop-data state after its read. Delete walks the list from the head one entry
// per cycle through one shared compare and address-increment unit, then moves every later
// entry down by one, again one entry per cycle, since the memory has one read port; a
// delete walks to the end of the list whether or not it finds a match. The core takes one
// item at a time and holds req_stall high until the result has been taken. Memory contents
// need no clearing after reset; entries beyond the count are never read.
module ordered_list_append_pop_delete_core #(
   parameter int unsigned DEPTH = olapd_pkg::DEPTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [1:0]                               req_type,
   input  logic signed [olapd_pkg::VALUE_WIDTH-1:0] req_item_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [1:0]                               rsp_status,
   output logic signed [olapd_pkg::VALUE_WIDTH-1:0] rsp_popped_value,
   output logic [olapd_pkg::COUNT_WIDTH-1:0]        rsp_entry_count
);
   import olapd_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned NW = AW + 1;

   logic signed [VALUE_WIDTH-1:0] mem [DEPTH];

   state_type state_ff, state_in;
   logic [NW-1:0] count_ff, count_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [1:0] op_ff, op_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic signed [VALUE_WIDTH-1:0] popped_ff, popped_in;

   logic mem_we, mem_re;
   logic [AW-1:0] wr_addr, rd_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;

   logic [AW-1:0] alu_a, alu_b, alu_sum;
   logic alu_equal;
   logic req_accept, is_last, list_full, list_empty;

   assign req_accept = req_valid && !req_stall;
   assign is_last    = ({1'b0, idx_ff} + NW'(1)) == count_ff;
   assign list_full  = count_ff == NW'(DEPTH);
   assign list_empty = count_ff == '0;

   olapd_alu #(.DEPTH(DEPTH)) u_alu (
      .addr_a    (alu_a),
      .addr_b    (alu_b),
      .cmp_a     (rd_data_ff),
      .cmp_b     (value_ff),
      .addr_sum  (alu_sum),
      .cmp_equal (alu_equal)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            state_in = S_RESP;
            if (op_ff == REQ_POP && !list_empty) state_in = S_POP_DATA;
            if (op_ff == REQ_DELETE && !list_empty) state_in = S_SCAN;
         end
         S_POP_DATA: state_in = S_RESP;
         S_SCAN: begin
            if (is_last) begin
               state_in = S_RESP;
            end else if (alu_equal) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (is_last) state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      popped_in    = popped_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      wr_addr      = wr_ptr_ff;
      rd_addr      = alu_sum;
      wr_data      = rd_data_ff;
      alu_a        = rd_ptr_ff;
      alu_b        = AW'(1);
      req_stall    = state_ff != S_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in    = req_type;
               value_in = req_item_value;
            end
         end
         S_DISPATCH: begin
            status_in = ST_OK;
            popped_in = '0;
            rd_addr   = head_ff;
            rd_ptr_in = head_ff;
            idx_in    = '0;
            unique case (op_ff)
               REQ_APPEND: begin
                  alu_a   = head_ff;
                  alu_b   = count_ff[AW-1:0];
                  wr_addr = alu_sum;
                  wr_data = value_ff;
                  if (list_full) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + NW'(1);
                  end
               end
               REQ_POP: begin
                  if (list_empty) status_in = ST_EMPTY;
                  else mem_re = 1'b1;
               end
               REQ_DELETE: begin
                  if (list_empty) status_in = ST_NOTFOUND;
                  else mem_re = 1'b1;
               end
               default: ;
            endcase
            if (!(op_ff == REQ_POP || op_ff == REQ_DELETE) || list_empty) begin
               rsp_valid_in = 1'b1;
            end
         end
         S_POP_DATA: begin
            alu_a        = head_ff;
            head_in      = alu_sum;
            count_in     = count_ff - NW'(1);
            popped_in    = rd_data_ff;
            rsp_valid_in = 1'b1;
         end
         S_SCAN: begin
            if (is_last) begin
               rsp_valid_in = 1'b1;
               if (alu_equal) count_in = count_ff - NW'(1);
               else status_in = ST_NOTFOUND;
            end else begin
               mem_re    = 1'b1;
               rd_ptr_in = alu_sum;
               idx_in    = idx_ff + AW'(1);
               if (alu_equal) wr_ptr_in = rd_ptr_ff;
            end
         end
         S_SHIFT: begin
            mem_we    = 1'b1;
            wr_ptr_in = rd_ptr_ff;
            if (is_last) begin
               count_in     = count_ff - NW'(1);
               rsp_valid_in = 1'b1;
            end else begin
               mem_re    = 1'b1;
               rd_ptr_in = alu_sum;
               idx_in    = idx_ff + AW'(1);
            end
         end
         S_RESP: begin
            if (!rsp_stall) rsp_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      idx_ff    <= idx_in;
      op_ff     <= op_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   // list storage
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      if (mem_re) rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_entry_count  = COUNT_WIDTH'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(DEPTH))
      else $error("entry count above depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> list_full)
      else $error("full status while list not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> list_empty && rsp_popped_value == '0)
      else $error("empty status with entries or nonzero value");

   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !rsp_valid)
      else $error("item accepted while result pending");

endmodule

>>> bench/olapd_checker.sv
// checker for the ordered list core: keeps a shadow list, predicts each result and compares
module olapd_checker #(
   parameter int unsigned DEPTH = olapd_pkg::DEPTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  logic [1:0]                               req_type,
   input  logic signed [olapd_pkg::VALUE_WIDTH-1:0] req_item_value,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic [1:0]                               rsp_status,
   input  logic signed [olapd_pkg::VALUE_WIDTH-1:0] rsp_popped_value,
   input  logic [olapd_pkg::COUNT_WIDTH-1:0]        rsp_entry_count,
   output int                                       fail_count,
   output int                                       pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import olapd_pkg::*;

   typedef struct packed {
      status_type                    status;
      logic signed [VALUE_WIDTH-1:0] popped;
      logic [COUNT_WIDTH-1:0]        count;
   } list_outcome_type;

   logic signed [VALUE_WIDTH-1:0] shadow_list [DEPTH];
   int unsigned                   shadow_count = 0;
   list_outcome_type              outcome_q [$];
   int                            errors = 0;

   function automatic void remove_entry(input int unsigned pos);
      for (int unsigned k = pos; k + 1 < shadow_count; k++) begin
         shadow_list[k] = shadow_list[k + 1];
      end
      shadow_count--;
   endfunction

   function automatic list_outcome_type apply_list_request(
      input logic [1:0]                    code,
      input logic signed [VALUE_WIDTH-1:0] value
   );
      list_outcome_type res;
      int               hit;
      res.status = ST_OK;
      res.popped = '0;
      hit = -1;
      case (code)
         REQ_APPEND: begin
            if (shadow_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_list[shadow_count] = value;
               shadow_count++;
            end
         end
         REQ_POP: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.popped = shadow_list[0];
               remove_entry(0);
            end
         end
         REQ_DELETE: begin
            for (int k = 0; k < int'(shadow_count); k++) begin
               if (hit < 0 && shadow_list[k] == value) hit = k;
            end
            if (hit < 0) begin
               res.status = ST_NOTFOUND;
            end else begin
               remove_entry(hit);
            end
         end
         default: ;
      endcase
      res.count = COUNT_WIDTH'(shadow_count);
      return res;
   endfunction

   task automatic check_field(input string name, input logic signed [VALUE_WIDTH-1:0] want,
                              input logic signed [VALUE_WIDTH-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t checker: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      list_outcome_type want;
      if (reset) begin
         shadow_count = 0;
         outcome_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               errors++;
               $display("%0t checker: result with no item outstanding, %s %0d",
                        $time, "expected none actual", rsp_status);
            end else begin
               want = outcome_q.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("popped_value", want.popped, rsp_popped_value);
               check_field("entry_count", want.count, rsp_entry_count);
            end
         end
         if (req_valid && !req_stall)
            outcome_q.push_back(apply_list_request(req_type, req_item_value));
      end
      fail_count <= errors;
      pending    <= outcome_q.size();
   end

endmodule

>>> bench/tb_top.sv
// testbench top for the ordered list core: request stimulus, result stalls and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import olapd_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic signed [VALUE_WIDTH-1:0] EXTREMES [4] =
      '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff};

   bit                            clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_type = REQ_APPEND;
   logic signed [VALUE_WIDTH-1:0] req_item_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_status;
   logic signed [VALUE_WIDTH-1:0] rsp_popped_value;
   logic [COUNT_WIDTH-1:0]        rsp_entry_count;
   int                            fail_count;
   int                            pending;
   int unsigned                   send_idle_pct = 24;
   int unsigned                   recv_idle_pct = 86;
   logic signed [VALUE_WIDTH-1:0] recent_values [$];

   ordered_list_append_pop_delete_core uut (.*);

   olapd_checker list_check (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_item(input logic [1:0] code, input logic signed [VALUE_WIDTH-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= code;
      req_item_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(9))
         0, 1:    return $signed($urandom_range(6)) - 3;
         2:       return EXTREMES[$urandom_range(3)];
         default: return $urandom();
      endcase
   endfunction

   task automatic send_random(input int unsigned mode);
      int unsigned                   roll;
      int unsigned                   append_pct;
      int unsigned                   pop_pct;
      logic [1:0]                    code;
      logic signed [VALUE_WIDTH-1:0] value;
      case (mode)
         0:       begin append_pct = 80; pop_pct = 10; end
         1:       begin append_pct = 15; pop_pct = 70; end
         default: begin append_pct = 45; pop_pct = 25; end
      endcase
      roll  = $urandom_range(99);
      value = pick_value();
      if (roll < 3) begin
         code = REQ_UNUSED;
      end else if (roll < 3 + append_pct) begin
         code = REQ_APPEND;
         recent_values.push_back(value);
         if (recent_values.size() > 24) void'(recent_values.pop_front());
      end else if (roll < 3 + append_pct + pop_pct) begin
         code = REQ_POP;
      end else begin
         code = REQ_DELETE;
         if (recent_values.size() > 0 && $urandom_range(9) < 7)
            value = recent_values[$urandom_range(recent_values.size() - 1)];
      end
      send_item(code, value);
   endtask

   initial begin
      int unsigned mode;
      mode = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty list corner cases
      send_item(REQ_POP, 32'sd0);
      send_item(REQ_DELETE, 32'sd0);
      send_item(REQ_UNUSED, -32'sd1);
      // extremes and duplicates
      send_item(REQ_APPEND, EXTREMES[0]);
      send_item(REQ_APPEND, EXTREMES[1]);
      send_item(REQ_APPEND, -32'sd1);
      send_item(REQ_APPEND, EXTREMES[1]);
      send_item(REQ_APPEND, 32'sd0);
      send_item(REQ_DELETE, EXTREMES[1]);
      send_item(REQ_DELETE, 32'sd5);
      send_item(REQ_UNUSED, EXTREMES[1]);
      send_item(REQ_DELETE, -32'sd1);
      send_item(REQ_POP, 32'sd0);
      send_item(REQ_POP, 32'sd0);
      send_item(REQ_APPEND, 32'sd7);
      send_item(REQ_DELETE, 32'sd0);
      send_item(REQ_POP, 32'sd0);
      send_item(REQ_POP, 32'sd0);
      wait_drained();

      for (int n = 0; n < 750; n++) begin
         if (n == 250) begin
            wait_drained();
            send_idle_pct = 86;
            recv_idle_pct = 24;
         end
         if (n == 500) begin
            wait_drained();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n % 30 == 0) mode = $urandom_range(2);
         send_random(mode);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

>>> filelist.f
hdl/olapd_pkg.sv
hdl/olapd_alu.sv
hdl/ordered_list_append_pop_delete_core.sv
bench/olapd_checker.sv
bench/tb_top.sv
